// ===== rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps
package ptt_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  // Widest slot index over the supported range (up to 256 slots).
  localparam int unsigned IDX_MAX_W = 8;
  localparam logic [31:0] WAIT_EMPTY_MS = 32'd3600000;

  typedef enum logic [2:0] {
    REQ_SET     = 3'd0,
    REQ_KILL    = 3'd1,
    REQ_KILLALL = 3'd2,
    REQ_TICK    = 3'd3,
    REQ_POLL    = 3'd4,
    REQ_WAIT    = 3'd5
  } ptt_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ptt_state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] timer_id;
    logic [31:0] period_ms;
    logic [15:0] elapsed_ms;
  } ptt_in_t;

  typedef struct packed {
    logic        status;
    logic        expired;
    logic [31:0] expired_id;
    logic [31:0] wait_ms;
    logic        was_empty;
  } ptt_out_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] period;
    logic [63:0] deadline;
  } ptt_entry_t;

  // Scan summary handed from the scan unit to the control.
  typedef struct packed {
    logic                 have_best;
    logic [IDX_MAX_W-1:0] best_idx;
    ptt_entry_t           best;
    logic                 match_found;
    logic [IDX_MAX_W-1:0] match_idx;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
  } ptt_scan_t;

endpackage

// ===== rtl/ptt_ram.sv =====
`timescale 1ns / 1ps
module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptt_scan.sv =====
`timescale 1ns / 1ps
module ptt_scan import ptt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  logic        rd_vld,
  input  logic [IW-1:0] rd_idx,
  input  logic        rd_used,
  input  ptt_entry_t  rd_entry,
  input  logic [31:0] match_id,
  output ptt_scan_t   scan
);

  logic          have_r, have_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  ptt_entry_t    best_r, best_nxt;
  logic          match_r, match_nxt;
  logic [IW-1:0] match_idx_r, match_idx_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          better, hit;

  // Earlier deadline wins, equal deadlines go to the lower key.
  assign better = !have_r || (rd_entry.deadline < best_r.deadline) ||
                  ((rd_entry.deadline == best_r.deadline) && (rd_entry.key < best_r.key));
  assign hit = rd_used && (rd_entry.key == match_id) && !match_r;

  always_comb begin
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    if (clear) begin
      have_nxt  = 1'b0;
      match_nxt = 1'b0;
      free_nxt  = 1'b0;
    end else if (rd_vld) begin
      if (rd_used && better) begin
        have_nxt     = 1'b1;
        best_idx_nxt = rd_idx;
        best_nxt     = rd_entry;
      end
      if (hit) begin
        match_nxt     = 1'b1;
        match_idx_nxt = rd_idx;
      end
      // A matching slot is freed before a set looks for room.
      if (!free_r && (!rd_used || hit)) begin
        free_nxt     = 1'b1;
        free_idx_nxt = rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      match_r <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      have_r  <= have_nxt;
      match_r <= match_nxt;
      free_r  <= free_nxt;
    end
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
  end

  always_comb begin
    scan             = '0;
    scan.have_best   = have_r;
    scan.best_idx    = IDX_MAX_W'(best_idx_r);
    scan.best        = best_r;
    scan.match_found = match_r;
    scan.match_idx   = IDX_MAX_W'(match_idx_r);
    scan.free_found  = free_r;
    scan.free_idx    = IDX_MAX_W'(free_idx_r);
  end

endmodule

// ===== rtl/periodic_timer_table_unit.sv =====
`timescale 1ns / 1ps
// Periodic timer table: up to SLOTS periodic timers keyed by a 32-bit id, with a
// 64-bit millisecond clock advanced by tick words. A word is taken when start is
// high and busy is low; exactly one result word follows, shown on out_word for a
// single cycle with out_valid high, and the receiver must take it then. Every
// word waits until the last one is through: the slot memory has a single port,
// so each word reads all SLOTS entries one per cycle, then a drain step empties
// the read pipe and a finish step applies the update and writes back at most one
// entry. Reset clears the table at once (valid bits in flip-flops), so no sweep
// is needed and the block is ready right after reset.
module periodic_timer_table_unit import ptt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ptt_in_t  in_word,
  output logic     out_valid,
  output ptt_out_t out_word
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  ptt_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ptt_in_t    req_r;
  logic [63:0] now_r, now_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;

  // read pipe alongside the RAM's registered output
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;

  logic          accept;
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  ptt_entry_t    ram_wdata, ram_rdata;
  ptt_scan_t     scan;

  logic          out_valid_r;
  ptt_out_t      out_word_r, res;

  logic [63:0] diff;
  logic        due;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  ptt_ram #(
    .WIDTH ($bits(ptt_entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ptt_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (accept),
    .rd_vld   (rd_vld_r),
    .rd_idx   (rd_idx_r),
    .rd_used  (used_r[rd_idx_r]),
    .rd_entry (ram_rdata),
    .match_id (req_r.timer_id),
    .scan     (scan)
  );

  // Wait to the earliest deadline, from the state before this word.
  assign diff = scan.best.deadline - now_r;
  assign due  = scan.have_best && (now_r >= scan.best.deadline);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    now_nxt   = now_r;
    used_nxt  = used_r;
    ram_we    = 1'b0;
    ram_addr  = cnt_r[IW-1:0];
    ram_wdata = scan.best;
    res       = '0;

    res.was_empty = !scan.have_best;
    if (!scan.have_best) begin
      res.wait_ms = WAIT_EMPTY_MS;
    end else if (due && (now_r != scan.best.deadline)) begin
      res.wait_ms = '0;
    end else if (diff[63:32] != '0) begin
      res.wait_ms = '1;
    end else begin
      res.wait_ms = diff[31:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
        unique case (req_r.req_type)
          REQ_SET: begin
            if (!scan.free_found) begin
              res.status = 1'b1;
            end else begin
              if (scan.match_found) begin
                used_nxt[scan.match_idx[IW-1:0]] = 1'b0;
              end
              used_nxt[scan.free_idx[IW-1:0]] = 1'b1;
              ram_we             = 1'b1;
              ram_addr           = scan.free_idx[IW-1:0];
              ram_wdata.key      = req_r.timer_id;
              ram_wdata.period   = req_r.period_ms;
              ram_wdata.deadline = now_r + {32'b0, req_r.period_ms};
            end
          end
          REQ_KILL: begin
            if (scan.match_found) begin
              used_nxt[scan.match_idx[IW-1:0]] = 1'b0;
            end
          end
          REQ_KILLALL: begin
            used_nxt = '0;
          end
          REQ_TICK: begin
            now_nxt = now_r + {48'b0, req_r.elapsed_ms};
          end
          REQ_POLL: begin
            if (due) begin
              res.expired        = 1'b1;
              res.expired_id     = scan.best.key;
              ram_we             = 1'b1;
              ram_addr           = scan.best_idx[IW-1:0];
              ram_wdata.deadline = scan.best.deadline + {32'b0, scan.best.period};
            end
          end
          default: begin
            // wait query and unused codes only report
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_FINISH);
    end
    cnt_r    <= cnt_nxt;
    rd_idx_r <= cnt_r[IW-1:0];
    if (accept) begin
      req_r <= in_word;
    end
    if (state_r == ST_FINISH) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the sequencing and on result consistency.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_FINISH))
    else $error("result strobe without finish step");

  a_expired_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.expired) |-> !out_word.was_empty)
    else $error("timer fired from an empty table");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status) |-> !out_word.was_empty)
    else $error("set refused on an empty table");

endmodule
